[rtl/iteration_count_palette_assert.svh]
// Assertion macros for the iteration count palette
`ifndef ITERATION_COUNT_PALETTE_ASSERT_SVH
`define ITERATION_COUNT_PALETTE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ICP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define ICP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/icp_pkg.sv]
// Shared types, constants and functions of the iteration count palette
package icp_pkg;

	localparam int COUNT_WIDTH_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [15:0] MAX_ITER_RST = 16'd100;
	localparam logic [1:0]  MODE_RST     = 2'd0;

	localparam logic REG_MAX_ITER = 1'b0;
	localparam logic REG_MODE     = 1'b1;

	localparam logic [1:0] MODE_POLY    = 2'd0;
	localparam logic [1:0] MODE_MAGENTA = 2'd1;
	localparam logic [1:0] MODE_ORANGE  = 2'd2;
	localparam logic [1:0] MODE_MIRROR  = 2'd3;

	localparam logic [14:0] C_9   = 15'd2295;
	localparam logic [14:0] C_15  = 15'd3825;
	localparam logic [14:0] C_17  = 15'd4335;
	localparam logic [14:0] C_1   = 15'd255;
	localparam logic [14:0] C_11  = 15'd2805;
	localparam logic [14:0] C_32  = 15'd8160;
	localparam logic [14:0] C_46  = 15'd11730;
	localparam logic [14:0] C_127 = 15'd32385;

	localparam logic [16:0] RECIP_5  = 17'd52429;
	localparam logic [16:0] RECIP_15 = 17'd69906;

	typedef enum logic [2:0] {
		DIV1,
		DIV2,
		DIV4,
		DIV5,
		DIV10,
		DIV15
	} div_t;

	typedef struct packed {
		logic vld;
		logic inter;
	} ctl_t;

	function automatic logic [7:0] chan_div(input logic [15:0] q, input div_t d);
		logic [33:0] p5;
		logic [33:0] p15;
		logic [15:0] v;
		p5  = 34'(q) * 34'(RECIP_5);
		p15 = 34'(q) * 34'(RECIP_15);
		case (d)
			DIV1:    v = q;
			DIV2:    v = q >> 1;
			DIV4:    v = q >> 2;
			DIV5:    v = p5[33:18];
			DIV10:   v = 16'(p5[33:19]);
			DIV15:   v = 16'(p15[33:20]);
			default: v = q;
		endcase
		return (v > 16'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage

[rtl/icp_div.sv]
// Pipelined restoring divider forming k = (count << F) / max
module icp_div #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  icp_pkg::ctl_t             ctl_in,
	input  logic [15:0]               count,
	input  logic [15:0]               maxv,
	output icp_pkg::ctl_t             ctl_out,
	output logic [FRACTION_BITS-1:0]  k
);
	import icp_pkg::*;

	localparam int F = FRACTION_BITS;

	ctl_t        ctl_s [0:F];
	logic [15:0] rem_s [0:F];
	logic [F-1:0] quo_s [0:F];

	assign ctl_s[0] = ctl_in;
	assign rem_s[0] = ctl_in.inter ? 16'd0 : count;
	assign quo_s[0] = '0;

	for (genvar i = 0; i < F; i++) begin : g_stage
		logic [16:0]  dbl;
		logic         ge;
		logic [15:0]  rem_n;
		logic [F-1:0] quo_n;

		always_comb begin
			dbl   = {rem_s[i], 1'b0};
			ge    = (dbl >= {1'b0, maxv});
			rem_n = ge ? 16'(dbl - {1'b0, maxv}) : dbl[15:0];
			quo_n = {quo_s[i][F-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_n;
				quo_s[i+1] <= quo_n;
			end
		end
	end

	assign ctl_out = ctl_s[F];
	assign k       = quo_s[F];

endmodule

[rtl/icp_poly.sv]
// Three multiply stages building the Bernstein terms
module icp_poly #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  icp_pkg::ctl_t             ctl_in,
	input  logic [FRACTION_BITS-1:0]  k_in,
	output icp_pkg::ctl_t             ctl_out,
	output logic [FRACTION_BITS-1:0]  k_out,
	output logic [FRACTION_BITS:0]    t1,
	output logic [FRACTION_BITS:0]    t2,
	output logic [FRACTION_BITS:0]    t3
);
	import icp_pkg::*;

	localparam int F = FRACTION_BITS;

	function automatic logic [F:0] qmul(input logic [F:0] a, input logic [F:0] b);
		logic [2*F+1:0] p;
		p = (2*F+2)'(a) * (2*F+2)'(b);
		return p[2*F:F];
	endfunction

	ctl_t         ctl_s1, ctl_s2, ctl_s3;
	logic [F-1:0] k_s1, k_s2, k_s3;
	logic [F:0]   j_s1;
	logic [F:0]   jk_s1, jj_s1;
	logic [F:0]   jkk_s2, jjk_s2, jjj_s2;
	logic [F:0]   t3_s3, t2_s3, t1_s3;
	logic [F:0]   k_w, j_w, k1_w, k2_w;

	assign k_w  = {1'b0, k_in};
	assign j_w  = (F+1)'(1) << F;
	assign k1_w = {1'b0, k_s1};
	assign k2_w = {1'b0, k_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1   <= k_in;
			j_s1   <= j_w - k_w;
			jk_s1  <= qmul(j_w - k_w, k_w);
			jj_s1  <= qmul(j_w - k_w, j_w - k_w);
			k_s2   <= k_s1;
			jkk_s2 <= qmul(jk_s1, k1_w);
			jjk_s2 <= qmul(jj_s1, k1_w);
			jjj_s2 <= qmul(jj_s1, j_s1);
			k_s3   <= k_s2;
			t3_s3  <= qmul(jkk_s2, k2_w);
			t2_s3  <= qmul(jjk_s2, k2_w);
			t1_s3  <= qmul(jjj_s2, k2_w);
		end
	end

	assign ctl_out = ctl_s3;
	assign k_out   = k_s3;
	assign t1      = t1_s3;
	assign t2      = t2_s3;
	assign t3      = t3_s3;

endmodule

[rtl/icp_chan.sv]
// Palette selection, channel scaling and saturation
module icp_chan #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  icp_pkg::ctl_t             ctl_in,
	input  logic [1:0]                mode,
	input  logic [FRACTION_BITS-1:0]  k,
	input  logic [FRACTION_BITS:0]    t1,
	input  logic [FRACTION_BITS:0]    t2,
	input  logic [FRACTION_BITS:0]    t3,
	output icp_pkg::ctl_t             ctl_out,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue
);
	import icp_pkg::*;

	localparam int F = FRACTION_BITS;

	logic [F:0]  tv [0:2];
	logic [14:0] cv [0:2];
	div_t        dv [0:2];
	logic [F:0]  kx;

	ctl_t        ctl_s1, ctl_s2;
	logic [15:0] q_s1 [0:2];
	div_t        d_s1 [0:2];
	logic [7:0]  c_s2 [0:2];

	assign kx = {1'b0, k};

	always_comb begin
		case (mode)
			MODE_POLY: begin
				tv[0] = t3; cv[0] = C_9;  dv[0] = DIV1;
				tv[1] = t2; cv[1] = C_15; dv[1] = DIV1;
				tv[2] = t1; cv[2] = C_17; dv[2] = DIV2;
			end
			MODE_MAGENTA: begin
				tv[0] = kx; cv[0] = C_1;  dv[0] = DIV1;
				tv[1] = kx; cv[1] = C_1;  dv[1] = DIV5;
				tv[2] = kx; cv[2] = C_11; dv[2] = DIV15;
			end
			MODE_ORANGE: begin
				tv[0] = kx; cv[0] = C_1;  dv[0] = DIV1;
				tv[1] = kx; cv[1] = C_1;  dv[1] = DIV4;
				tv[2] = '0; cv[2] = C_1;  dv[2] = DIV1;
			end
			default: begin
				tv[0] = t1; cv[0] = C_32;  dv[0] = DIV5;
				tv[1] = t2; cv[1] = C_46;  dv[1] = DIV5;
				tv[2] = t3; cv[2] = C_127; dv[2] = DIV10;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [F+15:0] prod;
		assign prod = (F+16)'(tv[c]) * (F+16)'(cv[c]);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s1[c] <= prod[F+15:F];
				d_s1[c] <= dv[c];
				if (ctl_s1.inter) begin
					c_s2[c] <= (mode == MODE_ORANGE) ? 8'd255 : 8'd0;
				end else begin
					c_s2[c] <= chan_div(q_s1[c], d_s1[c]);
				end
			end
		end
	end

	assign ctl_out = ctl_s2;
	assign red     = c_s2[0];
	assign green   = c_s2[1];
	assign blue    = c_s2[2];

endmodule

[rtl/iteration_count_palette.sv]
// Top level of the iteration count palette
// Maps one pixel's escape count to an RGB color. One item is taken per clock
// while the output is not stalled. The divider forms one quotient bit per stage
// and is followed by three multiply stages, two channel stages and the output
// register. A stall on the output freezes the whole pipeline.
// Write max_iterations and palette_mode only while no item is in flight.
module iteration_count_palette
	import icp_pkg::*;
#(
	parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // iteration_count
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // blue, green, red (red in the low byte)
);

	localparam logic [15:0] CNT_MASK = (COUNT_WIDTH >= 16) ? 16'hFFFF :
		16'((32'd1 << COUNT_WIDTH) - 32'd1);

	logic [15:0] max_iterations_q;
	logic [1:0]  palette_mode_q;
	logic        m_valid_q;
	logic [23:0] m_data_q;

	logic        en;
	logic [15:0] cnt;
	ctl_t        ctl_in, ctl_d, ctl_p, ctl_c;
	logic [FRACTION_BITS-1:0] k_d, k_p;
	logic [FRACTION_BITS:0]   t1, t2, t3;
	logic [7:0]  red, green, blue;

	assign en            = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cnt           = s_axis_tdata & CNT_MASK;
	assign ctl_in.vld    = s_axis_tvalid;
	assign ctl_in.inter  = (cnt >= max_iterations_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iterations_q <= MAX_ITER_RST;
			palette_mode_q   <= MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ITER: max_iterations_q <= cfg_data;
				REG_MODE:     palette_mode_q   <= cfg_data[1:0];
				default:      max_iterations_q <= max_iterations_q;
			endcase
		end
	end

	icp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_in(ctl_in), .count(cnt),
		.maxv(max_iterations_q), .ctl_out(ctl_d), .k(k_d)
	);

	icp_poly #(.FRACTION_BITS(FRACTION_BITS)) u_poly (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_in(ctl_d), .k_in(k_d),
		.ctl_out(ctl_p), .k_out(k_p), .t1(t1), .t2(t2), .t3(t3)
	);

	icp_chan #(.FRACTION_BITS(FRACTION_BITS)) u_chan (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_in(ctl_p), .mode(palette_mode_q),
		.k(k_p), .t1(t1), .t2(t2), .t3(t3), .ctl_out(ctl_c),
		.red(red), .green(green), .blue(blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= ctl_c.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_data_q <= {blue, green, red};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

[rtl/icp_checker.sv]
// Port-level checks of the iteration count palette and their binding
module icp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);
`include "iteration_count_palette_assert.svh"

	`ICP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")
	`ICP_ASSERT_NOW(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
	`ICP_ASSERT_NOW(a_ready_flow, m_axis_tready, s_axis_tready, "input stalled while output drains")

endmodule

bind iteration_count_palette icp_checker u_icp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

[tb/iteration_count_palette_checker.sv]
// Checker for the iteration count palette: predicts colors and compares output items
module iteration_count_palette_checker
	import icp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} color_t;

	logic [15:0] limit_q;
	logic [1:0]  mode_q;
	color_t      colors_due[$];

	function automatic logic [7:0] scale(input logic [63:0] t, input logic [63:0] num,
			input logic [63:0] den);
		logic [63:0] v;
		v = (t * 64'd255 * num) / (den << FB);
		return (v > 64'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [63:0] qm(input logic [63:0] a, input logic [63:0] b);
		return (a * b) >> FB;
	endfunction

	function automatic color_t paint(input logic [15:0] cnt);
		color_t c;
		logic [63:0] k, j, t1, t2, t3;
		if (cnt >= limit_q) begin
			c = (mode_q == MODE_ORANGE) ? 24'hFFFFFF : 24'h0;
			return c;
		end
		k = (64'(cnt) << FB) / 64'(limit_q);
		j = (64'd1 << FB) - k;
		t3 = qm(qm(qm(j, k), k), k);
		t2 = qm(qm(qm(j, j), k), k);
		t1 = qm(qm(qm(j, j), j), k);
		case (mode_q)
			MODE_POLY: begin
				c.red = scale(t3, 9, 1); c.green = scale(t2, 15, 1); c.blue = scale(t1, 17, 2);
			end
			MODE_MAGENTA: begin
				c.red = scale(k, 1, 1); c.green = scale(k, 1, 5); c.blue = scale(k, 11, 15);
			end
			MODE_ORANGE: begin
				c.red = scale(k, 1, 1); c.green = scale(k, 1, 4); c.blue = 8'd0;
			end
			default: begin
				c.red = scale(t1, 32, 5); c.green = scale(t2, 46, 5);
				c.blue = scale(t3, 127, 10);
			end
		endcase
		return c;
	endfunction

	assign pending = colors_due.size();

	always @(posedge clk or negedge arst_n) begin
		color_t got, want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			limit_q <= MAX_ITER_RST;
			mode_q <= MODE_RST;
			fail_count <= 0;
			colors_due.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				colors_due.push_back(paint(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (colors_due.size() == 0) begin
					$error("unexpected color item %h", m_axis_tdata);
					errs++;
				end else begin
					want = colors_due.pop_front();
					if (got.red !== want.red) begin
						$error("red expected %0d actual %0d", want.red, got.red);
						errs++;
					end
					if (got.green !== want.green) begin
						$error("green expected %0d actual %0d", want.green, got.green);
						errs++;
					end
					if (got.blue !== want.blue) begin
						$error("blue expected %0d actual %0d", want.blue, got.blue);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (cfg_we) begin
				if (cfg_index == REG_MAX_ITER)
					limit_q <= cfg_data;
				else
					mode_q <= cfg_data[1:0];
			end
		end
	end
endmodule

[tb/tb_iteration_count_palette.sv]
// Testbench top for the iteration count palette: stimulus, configuration and verdict
module tb_iteration_count_palette;
	timeunit 1ns;
	timeprecision 1ps;
	import icp_pkg::*;

	localparam int LATENCY = 16 + 6;
	localparam int LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	int          fail_count;
	int          pending;
	int          cycles;
	int          send_idle;
	int          sink_idle;
	int          hold_off;
	int          hold_start;
	int          hold_seen;
	int          sent;

	iteration_count_palette dut (.*);
	iteration_count_palette_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_off <= 0;
			hold_seen <= 0;
		end else if (hold_start != hold_seen) begin
			hold_seen <= hold_start;
			hold_off <= 200;
			m_axis_tready <= 1'b0;
		end else if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			m_axis_tready <= ($urandom_range(99) >= sink_idle);
	end

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_count(input logic [15:0] cnt);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= cnt;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic settle(input logic [15:0] lim, input logic [1:0] md);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		drain();
		write_reg(REG_MAX_ITER, lim);
		write_reg(REG_MODE, {14'd0, md});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(5))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(2, 20));
			3: return 16'($urandom_range(50, 300));
			4: return 16'd0;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_count(input logic [15:0] lim);
		case ($urandom_range(9))
			0: return 16'($urandom());
			1: return lim;
			2: return 16'd0;
			default: return (lim < 2) ? 16'($urandom_range(1)) :
				16'($urandom_range(lim - 1));
		endcase
	endfunction

	initial begin
		logic [15:0] lim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle = 0;
		sink_idle = 0;
		hold_start = 0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, then each mode at a small limit, then zero and full limits
		foreach (s_axis_tdata[i]) send_count(16'd1 << i);
		send_count(16'd0); send_count(16'd50); send_count(16'd99);
		for (int m = 0; m < 4; m++) begin
			settle(16'd10, 2'(m));
			send_count(16'd0); send_count(16'd5); send_count(16'd10); send_count(16'hFFFF);
		end
		settle(16'd0, MODE_ORANGE);
		send_count(16'd0); send_count(16'd7);
		settle(16'hFFFF, MODE_MIRROR);
		send_count(16'hFFFE); send_count(16'd30000);

		for (int ph = 0; ph < 24; ph++) begin
			send_idle = (ph < 8) ? 33 : (ph < 16) ? 52 : 0;
			sink_idle = (ph < 8) ? 52 : (ph < 16) ? 33 : 0;
			lim = pick_limit();
			settle(lim, 2'($urandom_range(3)));
			if (ph == 4 || ph == 18)
				hold_start <= hold_start + 1;
			repeat (78) send_count(pick_count(lim));
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		drain();
		$display("Sent %0d counts over 24 random settings and all four palette modes,", sent);
		$display("including zero and full limits, interior pixels and long output stalls.");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
